>>> sv/skfb_pkg.sv
// ----------------------------------------------------------------------------
// skfb_pkg
// Types and constants shared by the scalar Kalman filter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package skfb_pkg;

   localparam int GAIN_BITS = 16;
   localparam logic [16:0] GAIN_ONE = 17'h10000;

   localparam logic CMD_INIT   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef struct packed {
      logic               command;
      logic [3:0]         channel;
      logic signed [31:0] value;
      logic [31:0]        process_noise;
      logic [31:0]        measure_noise;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_channel;
      logic signed [31:0] estimate;
      logic [16:0]        gain;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, read channel state
      logic prep;       // form p + q and denominator
      logic div_start;  // begin gain division
      logic corr;       // multiply for correction and variance
      logic commit;     // write state, form result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic is_update;
   } sts_type;

endpackage

`default_nettype wire

>>> sv/skfb_ram.sv
// ----------------------------------------------------------------------------
// skfb_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module skfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> sv/skfb_ctrl.sv
// ----------------------------------------------------------------------------
// skfb_ctrl
// Sequencer: accept a request, step the datapath, hold the response.
// ----------------------------------------------------------------------------
`default_nettype none

module skfb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire skfb_pkg::sts_type sts,
   output skfb_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_PREP, ST_DIV, ST_MUL, ST_COMMIT, ST_RSP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_PREP;
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (sts.is_update) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.corr = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_RSP;
         end
         ST_RSP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      cmd.div_start = (state_ff == ST_PREP) && sts.is_update;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_only_in_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_RSP) else $error("response outside ST_RSP");
   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall) else $error("second request accepted");
   a_commit_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid) else $error("commit without response");

endmodule

`default_nettype wire

>>> sv/skfb_dp.sv
// ----------------------------------------------------------------------------
// skfb_dp
// Datapath: channel state memories, restoring gain divider, update math.
// ----------------------------------------------------------------------------
`default_nettype none

module skfb_dp #(
   parameter int CHANNELS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire skfb_pkg::req_type req,
   input  wire skfb_pkg::cmd_type cmd,
   output skfb_pkg::sts_type      sts,
   output skfb_pkg::rsp_type      rsp
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = (CHANNELS > 1) ? CHANNELS : 2;
   localparam logic [31:0] VAR_ONE = 32'(64'd1 << FRAC_BITS);
   localparam logic [4:0] DIV_STEPS = 5'd17;

   skfb_pkg::req_type req_ff;
   logic              in_range_ff;
   logic [AW-1:0]     addr;

   logic [31:0] est_rd, var_rd, q_rd, r_rd;
   logic        valid_ff [CHANNELS];

   logic [31:0] p_ff;
   logic [32:0] den_ff;
   logic [34:0] rem_ff;
   logic [16:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic [16:0] gain;
   logic signed [50:0] corr_ff;
   logic [48:0] pvar_ff;
   logic        upd_ff;

   skfb_pkg::rsp_type rsp_ff;

   assign addr = AW'(req_ff.channel);

   // entries never written read as their reset value
   logic [31:0] est_s, var_s, q_s, r_s;
   assign est_s = valid_ff[addr] ? est_rd : '0;
   assign var_s = valid_ff[addr] ? var_rd : VAR_ONE;
   assign q_s   = valid_ff[addr] ? q_rd : '0;
   assign r_s   = valid_ff[addr] ? r_rd : '0;

   logic        wr_en;
   logic [31:0] est_wr, var_wr, q_wr, r_wr;
   logic signed [50:0] nx_full;
   logic signed [31:0] nx_sat;

   assign nx_full = 51'(signed'(est_s)) + (corr_ff >>> skfb_pkg::GAIN_BITS);
   always_comb begin
      if (nx_full > 51'sd2147483647) begin
         nx_sat = 32'sh7fffffff;
      end else if (nx_full < -51'sd2147483648) begin
         nx_sat = 32'sh80000000;
      end else begin
         nx_sat = nx_full[31:0];
      end
   end

   assign wr_en  = cmd.commit && in_range_ff;
   assign est_wr = upd_ff ? nx_sat : req_ff.value;
   assign var_wr = upd_ff ? ((pvar_ff[48:16] > 33'hffffffff) ? 32'hffffffff
                   : pvar_ff[47:16]) : VAR_ONE;
   assign q_wr   = upd_ff ? q_s : req_ff.process_noise;
   assign r_wr   = upd_ff ? r_s : req_ff.measure_noise;

   skfb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_est (.clock, .wr_en, .wr_addr(addr),
      .wr_data(est_wr), .rd_addr(addr), .rd_data(est_rd));
   skfb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_var (.clock, .wr_en, .wr_addr(addr),
      .wr_data(var_wr), .rd_addr(addr), .rd_data(var_rd));
   skfb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_q (.clock, .wr_en, .wr_addr(addr),
      .wr_data(q_wr), .rd_addr(addr), .rd_data(q_rd));
   skfb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_r (.clock, .wr_en, .wr_addr(addr),
      .wr_data(r_wr), .rd_addr(addr), .rd_data(r_rd));

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (wr_en && addr == AW'(i)) begin
            valid_ff[i] <= 1'b1;
         end
      end
   end

   logic [32:0] psum;
   logic [31:0] p_new;
   logic [35:0] rem_try;
   assign psum    = {1'b0, var_s} + {1'b0, q_s};
   assign p_new   = psum[32] ? 32'hffffffff : psum[31:0];
   // restoring divider, one quotient bit per cycle
   assign rem_try = {1'b0, rem_ff} - {3'b0, den_ff};

   assign gain = (den_ff == '0) ? 17'd0
               : ((quo_ff > skfb_pkg::GAIN_ONE) ? skfb_pkg::GAIN_ONE : quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req;
         in_range_ff <= (32'(req.channel) < 32'(CHANNELS));
      end
      if (cmd.prep) begin
         upd_ff <= (req_ff.command == skfb_pkg::CMD_UPDATE) && in_range_ff;
         p_ff   <= p_new;
         den_ff <= {1'b0, p_new} + {1'b0, r_s};
         rem_ff <= {3'b0, p_new};
         quo_ff <= '0;
      end
      if (busy_ff) begin
         // dividend is p << 16: start from p, then double after each compare
         if (!rem_try[35]) begin
            rem_ff <= {rem_try[33:0], 1'b0};
            quo_ff <= {quo_ff[15:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[33:0], 1'b0};
            quo_ff <= {quo_ff[15:0], 1'b0};
         end
      end
      if (cmd.corr) begin
         corr_ff <= 51'((34'(signed'(req_ff.value)) - 34'(signed'(est_s)))
                    * signed'({1'b0, gain}));
         pvar_ff <= 49'(p_ff) * 49'(skfb_pkg::GAIN_ONE - gain);
      end
      if (cmd.commit) begin
         rsp_ff.out_channel <= req_ff.channel;
         rsp_ff.estimate    <= !in_range_ff ? 32'sd0 : (upd_ff ? nx_sat : req_ff.value);
         rsp_ff.gain        <= upd_ff ? gain : 17'd0;
      end
   end

   // run DIV_STEPS quotient steps after the start pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == DIV_STEPS - 5'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   logic div_done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= busy_ff && (cnt_ff == DIV_STEPS - 5'd1);
      end
   end

   assign sts.div_done  = div_done_ff;
   assign sts.is_update = (req_ff.command == skfb_pkg::CMD_UPDATE) && in_range_ff;
   assign rsp = rsp_ff;

endmodule

`default_nettype wire

>>> sv/scalar_kalman_filter_bank.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_bank
// Bank of one-dimensional Kalman filters, one per channel, Q16.16.
//
//   channel | ports               | payload
//   request | req_valid/req_stall | req_data  (skfb_pkg::req_type)
//   response| rsp_valid/rsp_stall | rsp_data  (skfb_pkg::rsp_type)
//
// An update runs the request through the 17-step restoring divider that
// forms the gain before its response is valid; an init skips the divider.
// One request at a time: the next request is taken only after the
// response has been taken.
// Reset clears the per-channel valid bits; unwritten channels read as
// their reset state. A stalled response holds until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_bank #(
   parameter int CHANNELS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire skfb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output skfb_pkg::rsp_type      rsp_data
);

   skfb_pkg::cmd_type cmd;
   skfb_pkg::sts_type sts;

   skfb_ctrl u_ctrl (.clock, .reset, .req_valid, .req_stall, .rsp_valid,
      .rsp_stall, .sts, .cmd);

   skfb_dp #(.CHANNELS(CHANNELS), .FRAC_BITS(FRAC_BITS)) u_dp (.clock, .reset,
      .req(req_data), .cmd, .sts, .rsp(rsp_data));

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scalar Kalman filter bank: drives init and
// update requests with random gaps, predicts each filter step per channel
// and compares every response field against the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int NCH = 16;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   skfb_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   skfb_pkg::rsp_type rsp_data;

   logic signed [31:0] est_mirror [NCH];
   logic [31:0] var_mirror [NCH];
   logic [31:0] q_mirror [NCH];
   logic [31:0] r_mirror [NCH];

   skfb_pkg::rsp_type pending_rsp [$];
   int errors = 0;
   int idle_cycles = 0;
   bit rsp_gaps = 1'b1;

   always #5 clock = ~clock;

   scalar_kalman_filter_bank DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void reset_filters();
      for (int i = 0; i < NCH; i++) begin
         est_mirror[i] = '0;
         var_mirror[i] = 32'h0001_0000;
         q_mirror[i] = '0;
         r_mirror[i] = '0;
      end
   endfunction

   // Advance one channel's filter and return the response it should give.
   function automatic skfb_pkg::rsp_type filter_step(skfb_pkg::req_type r);
      skfb_pkg::rsp_type res;
      logic [32:0] p;
      logic [33:0] den;
      logic [63:0] k;
      logic signed [33:0] diff;
      logic signed [63:0] prod, nx;
      logic [63:0] pv;
      int ch;
      ch = r.channel;
      res.out_channel = r.channel;
      res.estimate = '0;
      res.gain = '0;
      if (r.command == skfb_pkg::CMD_INIT) begin
         est_mirror[ch] = r.value;
         var_mirror[ch] = 32'h0001_0000;
         q_mirror[ch] = r.process_noise;
         r_mirror[ch] = r.measure_noise;
         res.estimate = r.value;
      end else begin
         p = {1'b0, var_mirror[ch]} + {1'b0, q_mirror[ch]};
         if (p[32]) p = 33'h0_FFFF_FFFF;
         den = {1'b0, p} + {2'b0, r_mirror[ch]};
         k = (den == 0) ? 64'd0 : ({31'd0, p} << 16) / {30'd0, den};
         if (k > 64'h1_0000) k = 64'h1_0000;
         diff = 34'(r.value) - 34'(est_mirror[ch]);
         prod = 64'(diff) * $signed({1'b0, k[62:0]});
         nx = 64'(est_mirror[ch]) + (prod >>> 16);
         if (nx > 64'sh7FFF_FFFF) nx = 64'sh7FFF_FFFF;
         if (nx < -64'sh8000_0000) nx = -64'sh8000_0000;
         est_mirror[ch] = nx[31:0];
         pv = ({31'd0, p} * (64'h1_0000 - k)) >> 16;
         if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;
         var_mirror[ch] = pv[31:0];
         res.estimate = nx[31:0];
         res.gain = k[16:0];
      end
      return res;
   endfunction

   task automatic send_request(skfb_pkg::req_type r);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(filter_step(r));
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return $urandom_range(0, 32'h0008_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic skfb_pkg::req_type make_req(logic cmd, logic [3:0] ch,
                                                  logic [31:0] v, logic [31:0] q,
                                                  logic [31:0] rn);
      skfb_pkg::req_type r;
      r.command = cmd;
      r.channel = ch;
      r.value = v;
      r.process_noise = q;
      r.measure_noise = rn;
      return r;
   endfunction

   task automatic test_extremes();
      // update before any init, then saturation cases
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd0, 32'h0001_0000, '1, '1));
      send_request(make_req(skfb_pkg::CMD_INIT, 4'd1, 32'd0, 32'd0, 32'd0));
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd1, 32'h7FFF_FFFF, 32'd0, 32'd0));
      send_request(make_req(skfb_pkg::CMD_INIT, 4'd2, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'd0));
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd2, 32'h7FFF_FFFF, '0, '0));
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd2, 32'h8000_0000, '0, '0));
      send_request(make_req(skfb_pkg::CMD_INIT, 4'd3, 32'h7FFF_FFFF, 32'd0,
                            32'hFFFF_FFFF));
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd3, 32'h8000_0000, '1, '1));
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd3, 32'h8000_0000, '1, '1));
      send_request(make_req(skfb_pkg::CMD_INIT, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd15, 32'h0000_0001, '0, '0));
      send_request(make_req(skfb_pkg::CMD_INIT, 4'd4, 32'd0, 32'd0, 32'h0001_0000));
      send_request(make_req(skfb_pkg::CMD_UPDATE, 4'd4, 32'hFFFF_FFFF, '0, '0));
   endtask

   task automatic test_random_tracking();
      // mostly updates on random channels, some inits
      for (int n = 0; n < 1700; n++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(make_req(skfb_pkg::CMD_INIT, 4'($urandom), rand_word(),
                                  rand_word(), rand_word()));
         else
            send_request(make_req(skfb_pkg::CMD_UPDATE, 4'($urandom), rand_word(),
                                  $urandom, $urandom));
         if (n == 850) rsp_gaps = 1'b0;
         if (n == 1100) rsp_gaps = 1'b1;
      end
   endtask

   // response stall pattern
   initial begin
      int g;
      forever begin
         @(posedge clock);
         g = rsp_gaps ? gap_len() : 0;
         if (g > 0) begin
            rsp_stall <= 1'b1;
            repeat (g) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      skfb_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response channel=%0d", rsp_data.out_channel);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.out_channel !== exp_rsp.out_channel) begin
               $error("out_channel: expected %0d, got %0d",
                      exp_rsp.out_channel, rsp_data.out_channel);
               errors++;
            end
            if (rsp_data.estimate !== exp_rsp.estimate) begin
               $error("estimate: expected %0d, got %0d",
                      exp_rsp.estimate, rsp_data.estimate);
               errors++;
            end
            if (rsp_data.gain !== exp_rsp.gain) begin
               $error("gain: expected %0d, got %0d", exp_rsp.gain, rsp_data.gain);
               errors++;
            end
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset_filters();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random_tracking();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
